### hdl/rpa_pkg.sv
// ----------------------------------------------------------------------------
// rpa_pkg
// shared types and codes of the rotor product alu
// ----------------------------------------------------------------------------
package rpa_pkg;

    localparam int DATA_W = 32;
    localparam int PROD_W = 64;
    localparam int ACC_W  = 68;

    typedef enum logic [2:0] {
        OP_ADD   = 3'd0,
        OP_SUB   = 3'd1,
        OP_INNER = 3'd2,
        OP_OUTER = 3'd3,
        OP_GEO   = 3'd4
    } op_t;

    localparam logic [2:0] K_SCALAR   = 3'd0;
    localparam logic [2:0] K_VECTOR   = 3'd1;
    localparam logic [2:0] K_BIVECTOR = 3'd2;
    localparam logic [2:0] K_PSEUDO   = 3'd3;
    localparam logic [2:0] K_ROTOR    = 3'd4;

    // one product term: operand pair select and sign, or unused
    typedef struct packed {
        logic       en;
        logic       neg;
        logic [1:0] ia;
        logic [1:0] ib;
    } term_t;

    // per lane: direct add/sub mode plus up to four product terms
    typedef struct packed {
        logic       lin;
        logic       lin_sub;
        term_t [3:0] t;
    } lane_ctl_t;

endpackage

### hdl/rotor_product_alu_top.sv
// ----------------------------------------------------------------------------
// rotor_product_alu_top
// geometric product alu for 3d rotors, four component lanes in parallel
// ----------------------------------------------------------------------------
// channel  | ports       | fields (low bit first)
// request  | s_axis_t*   | tuser: op, kind_a, kind_b; tdata: a_part0..3, b_part0..3
// result   | m_axis_t*   | tdata: res_scalar, res_e12, res_e23, res_e31;
//          |             | tuser: unsupported, saturated
// one request per cycle unless the output stalls; stages: decode and multiply, then sum,
// clamp and output register
// each lane carries four 32x32 multipliers, one per product term
// stalls freeze the whole pipeline; reset empties it
module rotor_product_alu_top import rpa_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [8:0]   s_axis_tuser,  // op, kind_a, kind_b
    input  logic [255:0] s_axis_tdata,  // a_part0..3, b_part0..3
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [127:0] m_axis_tdata,  // res_scalar, res_e12, res_e23, res_e31
    output logic [1:0]   m_axis_tuser   // unsupported, saturated
);

    logic signed [DATA_W-1:0] pa [4];
    logic signed [DATA_W-1:0] pb [4];
    logic signed [DATA_W-1:0] a [4];
    logic signed [DATA_W-1:0] b [4];
    logic signed [DATA_W-1:0] res [4];
    lane_ctl_t                ctl [4];
    logic [3:0]               sat;
    logic                     ok;
    logic                     v1_reg, ok1_reg;
    logic                     v2_reg;
    logic [127:0]             out_reg;
    logic [1:0]               user_reg;
    logic                     adv;

    assign adv = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = adv;
    assign m_axis_tvalid = v2_reg;
    assign m_axis_tdata = out_reg;
    assign m_axis_tuser = user_reg;

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            pa[i] = s_axis_tdata[32*i +: 32];
            pb[i] = s_axis_tdata[128 + 32*i +: 32];
        end
    end

    rpa_decode u_dec (
        .op(s_axis_tuser[2:0]), .kind_a(s_axis_tuser[5:3]), .kind_b(s_axis_tuser[8:6]),
        .pa(pa), .pb(pb), .a(a), .b(b), .ctl(ctl), .ok(ok)
    );

    for (genvar g = 0; g < 4; g++) begin : g_lane
        rpa_lane #(.FRAC_BITS(FRAC_BITS)) u_lane (
            .aclk(aclk), .en(adv), .ctl(ctl[g]),
            .a(a), .b(b), .lin_idx(2'(g)), .res(res[g]), .sat(sat[g])
        );
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else if (adv) begin
            v1_reg <= s_axis_tvalid;
            v2_reg <= v1_reg;
        end
    end

    // merge stage: lane results and flags
    always_ff @(posedge aclk) begin
        if (adv) begin
            ok1_reg  <= ok;
            out_reg  <= {res[3], res[2], res[1], res[0]};
            user_reg <= {|sat, !ok1_reg};
        end
    end

endmodule

### hdl/rpa_lane.sv
// ----------------------------------------------------------------------------
// rpa_lane
// one result component: four truncated products or a direct add/subtract,
// then exact sum and clamp
// ----------------------------------------------------------------------------
module rpa_lane import rpa_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  logic                     aclk,
    input  logic                     en,
    input  lane_ctl_t                ctl,
    input  logic signed [DATA_W-1:0] a [4],
    input  logic signed [DATA_W-1:0] b [4],
    input  logic [1:0]               lin_idx,
    output logic signed [DATA_W-1:0] res,
    output logic                     sat
);

    logic signed [PROD_W-1:0] prod_reg [4];
    logic signed [PROD_W-1:0] prod_next [4];
    logic                     neg_reg [4];
    logic signed [ACC_W-1:0]  sum;
    logic signed [ACC_W-1:0]  tr;

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            if (ctl.lin) begin
                prod_next[i] = '0;
                if (i == 0) begin
                    prod_next[i] = PROD_W'(a[lin_idx]) <<< FRAC_BITS;
                end else if (i == 1) begin
                    prod_next[i] = PROD_W'(b[lin_idx]) <<< FRAC_BITS;
                end
            end else if (ctl.t[i].en) begin
                prod_next[i] = PROD_W'(a[ctl.t[i].ia]) * PROD_W'(b[ctl.t[i].ib]);
            end else begin
                prod_next[i] = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 4; i++) begin
                prod_reg[i] <= prod_next[i];
                neg_reg[i]  <= (ctl.lin && i == 1) ? ctl.lin_sub : ctl.t[i].neg;
            end
        end
    end

    always_comb begin
        sum = '0;
        for (int i = 0; i < 4; i++) begin
            tr = ACC_W'(prod_reg[i] >>> FRAC_BITS);
            sum = neg_reg[i] ? sum - tr : sum + tr;
        end
        sat = 1'b0;
        res = sum[DATA_W-1:0];
        if (sum > ACC_W'(signed'(32'h7fffffff))) begin
            sat = 1'b1;
            res = 32'sh7fffffff;
        end else if (sum < -ACC_W'(64'sh80000000)) begin
            sat = 1'b1;
            res = 32'sh80000000;
        end
    end

endmodule

### hdl/rpa_decode.sv
// ----------------------------------------------------------------------------
// rpa_decode
// maps operation and operand kinds to lane term lists and masked operands
// ----------------------------------------------------------------------------
module rpa_decode import rpa_pkg::*; (
    input  logic [2:0]               op,
    input  logic [2:0]               kind_a,
    input  logic [2:0]               kind_b,
    input  logic signed [DATA_W-1:0] pa [4],
    input  logic signed [DATA_W-1:0] pb [4],
    output logic signed [DATA_W-1:0] a [4],
    output logic signed [DATA_W-1:0] b [4],
    output lane_ctl_t                ctl [4],
    output logic                     ok
);

    logic ev_a, ev_b;

    function automatic term_t tm(input logic n, input logic [1:0] x, input logic [1:0] y);
        term_t t;
        t.en = 1'b1;
        t.neg = n;
        t.ia = x;
        t.ib = y;
        return t;
    endfunction

    always_comb begin
        ev_a = kind_a == K_SCALAR || kind_a == K_BIVECTOR || kind_a == K_ROTOR;
        ev_b = kind_b == K_SCALAR || kind_b == K_BIVECTOR || kind_b == K_ROTOR;
        for (int i = 0; i < 4; i++) begin
            ctl[i] = '0;
            a[i] = pa[i];
            b[i] = pb[i];
        end
        ok = 1'b0;
        if (op <= OP_GEO && ev_a && ev_b) begin
            ok = 1'b1;
            if (kind_a == K_BIVECTOR) a[0] = '0;
            if (kind_a == K_SCALAR) begin
                a[1] = '0; a[2] = '0; a[3] = '0;
            end
            if (kind_b == K_BIVECTOR) b[0] = '0;
            if (kind_b == K_SCALAR) begin
                b[1] = '0; b[2] = '0; b[3] = '0;
            end
            if (op == OP_ADD || op == OP_SUB) begin
                for (int i = 0; i < 4; i++) begin
                    ctl[i].lin = 1'b1;
                    ctl[i].lin_sub = (op == OP_SUB);
                end
            end else begin
                ctl[0].t[0] = tm(1'b0, 2'd0, 2'd0);
                if (op != OP_OUTER) begin
                    ctl[0].t[1] = tm(1'b1, 2'd1, 2'd1);
                    ctl[0].t[2] = tm(1'b1, 2'd2, 2'd2);
                    ctl[0].t[3] = tm(1'b1, 2'd3, 2'd3);
                end
                for (int i = 1; i < 4; i++) begin
                    ctl[i].t[0] = tm(1'b0, 2'd0, 2'(i));
                    ctl[i].t[1] = tm(1'b0, 2'(i), 2'd0);
                end
                if (op == OP_GEO) begin
                    ctl[1].t[2] = tm(1'b1, 2'd2, 2'd3);
                    ctl[1].t[3] = tm(1'b0, 2'd3, 2'd2);
                    ctl[2].t[2] = tm(1'b0, 2'd1, 2'd3);
                    ctl[2].t[3] = tm(1'b1, 2'd3, 2'd1);
                    ctl[3].t[2] = tm(1'b1, 2'd1, 2'd2);
                    ctl[3].t[3] = tm(1'b0, 2'd2, 2'd1);
                end
            end
        end else if (op >= OP_INNER && op <= OP_GEO) begin
            if (kind_a == K_PSEUDO && kind_b == K_PSEUDO) begin
                ok = 1'b1;
                if (op != OP_OUTER) ctl[0].t[0] = tm(1'b1, 2'd0, 2'd0);
            end else if (kind_a == K_PSEUDO && kind_b == K_VECTOR) begin
                ok = 1'b1;
                if (op != OP_OUTER) begin
                    ctl[1].t[0] = tm(1'b0, 2'd0, 2'd3);
                    ctl[2].t[0] = tm(1'b0, 2'd0, 2'd1);
                    ctl[3].t[0] = tm(1'b0, 2'd0, 2'd2);
                end
            end else if (kind_a == K_VECTOR && kind_b == K_PSEUDO) begin
                ok = 1'b1;
                if (op != OP_OUTER) begin
                    ctl[1].t[0] = tm(1'b0, 2'd3, 2'd0);
                    ctl[2].t[0] = tm(1'b0, 2'd1, 2'd0);
                    ctl[3].t[0] = tm(1'b0, 2'd2, 2'd0);
                end
            end else if (kind_a == K_VECTOR && kind_b == K_VECTOR) begin
                ok = 1'b1;
                if (op != OP_OUTER) begin
                    ctl[0].t[0] = tm(1'b0, 2'd1, 2'd1);
                    ctl[0].t[1] = tm(1'b0, 2'd2, 2'd2);
                    ctl[0].t[2] = tm(1'b0, 2'd3, 2'd3);
                end
                if (op != OP_INNER) begin
                    ctl[1].t[0] = tm(1'b0, 2'd1, 2'd2);
                    ctl[1].t[1] = tm(1'b1, 2'd2, 2'd1);
                    ctl[2].t[0] = tm(1'b0, 2'd2, 2'd3);
                    ctl[2].t[1] = tm(1'b1, 2'd3, 2'd2);
                    ctl[3].t[0] = tm(1'b1, 2'd1, 2'd3);
                    ctl[3].t[1] = tm(1'b0, 2'd3, 2'd1);
                end
            end else if (op == OP_OUTER && ((kind_a == K_PSEUDO && kind_b == K_BIVECTOR) ||
                                            (kind_a == K_BIVECTOR && kind_b == K_PSEUDO))) begin
                ok = 1'b1;
            end
        end
    end

endmodule

### hdl/rpa_checker.sv
// ----------------------------------------------------------------------------
// rpa_checker
// port level checks of the rotor product alu
// ----------------------------------------------------------------------------
module rpa_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_axis_tready,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [127:0] m_axis_tdata,
    input logic [1:0]   m_axis_tuser
);

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result changed under stall");

    a_unsup_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == '0 && !m_axis_tuser[1])
        else $error("unsupported result not zero");

    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("request stalled with empty output");

    a_ready_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> s_axis_tready == m_axis_tready)
        else $error("request ready does not follow result ready");

endmodule

bind rotor_product_alu_top rpa_checker u_rpa_checker (
    .aclk(aclk), .aresetn(aresetn),
    .s_axis_tready(s_axis_tready), .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser)
);
